### src/assert_macros.svh
// Assertion macros shared by the frame receiver modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define WSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WSFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wsfr_pkg.sv
// Types, constants and helpers for the WebSocket frame receiver.
// No dependencies; imported by wsfr_parser and websocket_frame_receiver.
package wsfr_pkg;

  localparam int LEN_W = 64;  // widest frame length accepted

  localparam logic [62:0] MAXLEN_RST   = 63'd1048500;
  localparam logic [15:0] CLOSE_NOCODE = 16'd1005;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } wsfr_phase_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PROTOCOL = 2'd1,
    ERR_TOO_LONG = 2'd2
  } wsfr_err_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [3:0]  frame_opcode;
    logic        frame_end;
    logic        message_end;
    logic        close_valid;
    logic [15:0] close_code;
    wsfr_err_t   error_kind;
  } wsfr_result_t;

  function automatic logic is_ctrl(input logic [3:0] op);
    return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

### src/wsfr_parser.sv
// Frame header parser and payload unmasker: one byte in, at most one word out.
// Depends on wsfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take_i,
  input  logic [7:0]            byte_i,
  input  logic [62:0]           max_len_i,
  output logic                  res_valid_o,
  output wsfr_pkg::wsfr_result_t res_o
);
  import wsfr_pkg::*;

  wsfr_phase_t phase_r, phase_nxt;
  logic [7:0]  fhb_r, fhb_nxt;
  logic [3:0]  ext_r, ext_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [3:0]  hsize_r, hsize_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic        halted_r, halted_nxt;

  logic [3:0]  op;
  logic        fin;
  logic        rsv_set;
  logic [6:0]  len7;
  logic [3:0]  ext_w;
  logic        fail_early;
  logic [63:0] rem_w;
  logic [1:0]  ksel;
  logic [7:0]  dbyte;
  logic [63:0] rem_dec;
  logic        last;
  logic        too_long;
  logic [15:0] cc_w;

  assign op      = fhb_r[3:0];
  assign fin     = fhb_r[7];
  assign rsv_set = fhb_r[6:4] != 3'd0;
  assign len7    = byte_i[6:0];
  assign ext_w   = (len7 == LEN7_EXT64) ? 4'd8 : ((len7 == LEN7_EXT16) ? 4'd2 : 4'd0);
  assign ksel    = 2'd3 - mpos_r;
  assign dbyte   = byte_i ^ key_r[{ksel, 3'b000} +: 8];
  assign rem_dec = rem_r - 64'd1;
  assign last    = rem_dec == 64'd0;
  assign cc_w    = {cc_r[7:0], dbyte};

  always_comb begin
    phase_nxt  = phase_r;
    fhb_nxt    = fhb_r;
    ext_nxt    = ext_r;
    hcnt_nxt   = hcnt_r;
    hsize_nxt  = hsize_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    mpos_nxt   = mpos_r;
    cc_nxt     = cc_r;
    pidx_nxt   = pidx_r;
    halted_nxt = halted_r;
    fail_early = 1'b0;
    rem_w      = rem_r;
    too_long   = 1'b0;

    res_valid_o        = 1'b0;
    res_o              = '0;
    res_o.frame_opcode = op;
    res_o.error_kind   = ERR_NONE;

    if (take_i && !halted_r) begin
      unique case (phase_r)
        PH_FIRST: begin
          fhb_nxt   = byte_i;
          hcnt_nxt  = 4'd1;
          hsize_nxt = 4'd2;
          rem_nxt   = '0;
          key_nxt   = '0;
          mpos_nxt  = '0;
          cc_nxt    = '0;
          pidx_nxt  = '0;
          phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          if (hcnt_r <= 4'd1) begin
            if (is_ctrl(op) && (rsv_set || len7 > LEN7_CTRL_MAX)) begin
              fail_early = 1'b1;
            end else begin
              ext_nxt   = ext_w;
              hsize_nxt = 4'd2 + ext_w + (byte_i[7] ? 4'd4 : 4'd0);
              if (len7 < LEN7_EXT16) rem_w = {57'd0, len7};
              hcnt_nxt  = 4'd2;
            end
          end else begin
            if (hcnt_r < 4'd2 + ext_r) rem_w = {rem_r[55:0], byte_i};
            else key_nxt = {key_r[23:0], byte_i};
            hcnt_nxt = hcnt_r + 4'd1;
          end
          rem_nxt = rem_w;

          if (fail_early) begin
            halted_nxt       = 1'b1;
            res_valid_o      = 1'b1;
            res_o.error_kind = ERR_PROTOCOL;
          end else if (hcnt_nxt >= hsize_nxt) begin
            // header complete: frame checks in priority order
            too_long = (rem_w > {1'b0, max_len_i}) ||
                       ((LEN_W < 64) && ((rem_w >> LEN_W) != 64'd0));
            priority if (too_long) begin
              halted_nxt       = 1'b1;
              res_valid_o      = 1'b1;
              res_o.error_kind = ERR_TOO_LONG;
            end else if (rsv_set || (op > OP_BINARY && !is_ctrl(op)) ||
                         (is_ctrl(op) && !fin)) begin
              halted_nxt       = 1'b1;
              res_valid_o      = 1'b1;
              res_o.error_kind = ERR_PROTOCOL;
            end else if (rem_w != 64'd0) begin
              phase_nxt = PH_DATA;
            end else begin
              // empty frame: one word without data
              phase_nxt         = PH_FIRST;
              res_valid_o       = 1'b1;
              res_o.frame_end   = 1'b1;
              res_o.message_end = fin;
              if (op == OP_CLOSE) begin
                halted_nxt        = 1'b1;
                res_o.close_valid = 1'b1;
                res_o.close_code  = CLOSE_NOCODE;
              end
            end
          end
        end
        PH_DATA: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_dec;
          if (last) phase_nxt = PH_FIRST;
          if (op == OP_CLOSE) begin
            if (pidx_r < 2'd2) begin
              // first two bytes build the status code
              cc_nxt   = cc_w;
              pidx_nxt = pidx_r + 2'd1;
              if (last) begin
                halted_nxt  = 1'b1;
                res_valid_o = 1'b1;
                if (pidx_r == 2'd0) begin
                  res_o.error_kind = ERR_PROTOCOL;
                end else begin
                  res_o.frame_end   = 1'b1;
                  res_o.message_end = fin;
                  res_o.close_valid = 1'b1;
                  res_o.close_code  = cc_w;
                end
              end
            end else begin
              res_valid_o      = 1'b1;
              res_o.data_valid = 1'b1;
              res_o.data_byte  = dbyte;
              if (last) begin
                halted_nxt        = 1'b1;
                res_o.frame_end   = 1'b1;
                res_o.message_end = fin;
                res_o.close_valid = 1'b1;
                res_o.close_code  = cc_r;
              end
            end
          end else begin
            res_valid_o       = 1'b1;
            res_o.data_valid  = 1'b1;
            res_o.data_byte   = dbyte;
            res_o.frame_end   = last;
            res_o.message_end = last && fin;
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      fhb_r    <= '0;
      ext_r    <= '0;
      hcnt_r   <= '0;
      hsize_r  <= 4'd2;
      rem_r    <= '0;
      key_r    <= '0;
      mpos_r   <= '0;
      cc_r     <= '0;
      pidx_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fhb_r    <= fhb_nxt;
      ext_r    <= ext_nxt;
      hcnt_r   <= hcnt_nxt;
      hsize_r  <= hsize_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      mpos_r   <= mpos_nxt;
      cc_r     <= cc_nxt;
      pidx_r   <= pidx_nxt;
      halted_r <= halted_nxt;
    end
  end

  `WSFR_ASSERT(a_halt_silent, halted_r |-> !res_valid_o, "halted parser produced a word")
  `WSFR_ASSERT(a_data_nonzero, (phase_r == PH_DATA) |-> (rem_r != 64'd0),
               "payload phase with zero bytes left")
  `WSFR_ASSERT(a_close_halts, (res_valid_o && res_o.close_valid) |=> halted_r,
               "completed close did not halt")

endmodule

### src/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: config register, parser and output skid.
// Depends on wsfr_pkg, wsfr_parser and assert_macros.svh.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | in_byte
//   out_    | out | out_valid/out_stall| data/opcode/end flags/close code/error
//   cfg_    | in  | cfg_wr_en          | cfg_wr_data (max payload length)
//
// One byte is taken every cycle while in_stall is low. Its word, if any, is registered
// in the output register, or in the skid register while out_stall holds a full output
// register. in_stall rises only while the skid holds a word. Reset is synchronous,
// clears parser state and both output slots and loads the length limit with MAXLEN_RST.
// After an error or a completed close all bytes are taken and dropped until reset.
`include "assert_macros.svh"

module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_frame_end,
  output logic        out_message_end,
  output logic        out_close_valid,
  output logic [15:0] out_close_code,
  output logic [1:0]  out_error_kind,
  input  logic        cfg_wr_en,
  input  logic [62:0] cfg_wr_data
);
  import wsfr_pkg::*;

  logic [62:0]  max_len_r;
  logic         take;
  logic         res_valid;
  wsfr_result_t res;

  logic         out_v_r, out_v_nxt;
  wsfr_result_t out_d_r, out_d_nxt;
  logic         skid_v_r, skid_v_nxt;
  wsfr_result_t skid_d_r, skid_d_nxt;
  logic         pop;

  assign in_stall = skid_v_r;
  assign take     = in_valid && !skid_v_r;
  assign pop      = out_v_r && !out_stall;

  wsfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_i     (take),
    .byte_i     (in_byte),
    .max_len_i  (max_len_r),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= MAXLEN_RST;
    else if (cfg_wr_en) max_len_r <= cfg_wr_data;
  end

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      out_v_nxt = 1'b0;
    end
    priority if (skid_v_r && pop) begin
      // skid full means no new word this cycle
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else if (res_valid && out_v_r && !pop) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end else if (res_valid) begin
      out_v_nxt = 1'b1;
      out_d_nxt = res;
    end else begin
      out_v_nxt = out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_data_valid   = out_d_r.data_valid;
  assign out_data_byte    = out_d_r.data_byte;
  assign out_frame_opcode = out_d_r.frame_opcode;
  assign out_frame_end    = out_d_r.frame_end;
  assign out_message_end  = out_d_r.message_end;
  assign out_close_valid  = out_d_r.close_valid;
  assign out_close_code   = out_d_r.close_code;
  assign out_error_kind   = 2'(out_d_r.error_kind);

  `WSFR_ASSERT(a_skid_behind_out, skid_v_r |-> out_v_r, "skid holds a word ahead of output")
  `WSFR_ASSERT(a_skid_catch, (out_v_r && out_stall && res_valid) |=> skid_v_r,
               "word lost while output stalled")
  `WSFR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_v_r && !skid_v_r),
                      "output slots not empty after reset")

endmodule
